@@ sv/qdsf_pkg.sv @@
package qdsf_pkg;

    // Largest d by default; d^4 then still fits 64 bits.
    localparam int MAX_D_DEFAULT = 65535;
    localparam int IDX_W         = 17;
    localparam int D_W           = 16;
    localparam int DIFF_W        = 64;
    localparam logic [D_W-1:0] LIMIT_RESET = 16'hFFFF;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 4;

    typedef enum logic [3:0] {
        RSN_OK      = 4'd0,
        RSN_RANGE   = 4'd1,
        RSN_DRES    = 4'd2,
        RSN_MOD625  = 4'd3,
        RSN_MOD9    = 4'd4,
        RSN_CMOD8   = 4'd5,
        RSN_MOD4096 = 4'd6,
        RSN_BITMAP  = 4'd7,
        RSN_TABLES  = 4'd8,
        RSN_V5      = 4'd9
    } t_reason;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] flag_index;
        logic             flag_value;
        logic [D_W-1:0]   larger;
        logic [D_W-1:0]   smaller;
    } t_req_item;

    typedef struct packed {
        logic              accepted;
        logic [DIFF_W-1:0] difference;
        t_reason           reject_reason;
    } t_result;

    // One classified item as it waits in the queue.
    typedef struct packed {
        logic             is_test;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             wr_val;
        logic [D_W-1:0]   larger;
        logic [D_W-1:0]   smaller;
        logic             range_ok;
        logic [IDX_W-1:0] addr_lo;
        logic [IDX_W-1:0] addr_hi;
    } t_work;

    // Moduli of the fourth-power residue chains. The first one feeds the
    // mod 625 equality check, the others the sum-of-two-quartics tables.
    localparam int NMOD = 7;
    localparam logic [11:0] MODS [NMOD] = '{
        12'd625, 12'd256, 12'd729, 12'd343, 12'd121, 12'd169, 12'd841
    };
    localparam logic [31:0] RCPS [NMOD] = '{
        32'((64'd1 << 32) / 64'd625),
        32'((64'd1 << 32) / 64'd256),
        32'((64'd1 << 32) / 64'd729),
        32'((64'd1 << 32) / 64'd343),
        32'((64'd1 << 32) / 64'd121),
        32'((64'd1 << 32) / 64'd169),
        32'((64'd1 << 32) / 64'd841)
    };
    localparam logic [11:0] M_3    = 12'd3;
    localparam logic [11:0] M_5    = 12'd5;
    localparam logic [11:0] M_3125 = 12'd3125;
    localparam logic [31:0] RCP_3    = 32'((64'd1 << 32) / 64'd3);
    localparam logic [31:0] RCP_5    = 32'((64'd1 << 32) / 64'd5);
    localparam logic [31:0] RCP_3125 = 32'((64'd1 << 32) / 64'd3125);
    localparam logic [39:0] M5_8     = 40'd390625;
    localparam logic [21:0] RCP_5_8  = 22'((64'd1 << 40) / 64'd390625);

    // x mod m for x below 2^20 by a reciprocal multiply; the estimated
    // quotient is at most one short, so one conditional subtract fixes it.
    function automatic logic [19:0] mod_small(input logic [19:0] x, input logic [11:0] m,
                                              input logic [31:0] recip);
        logic [51:0] p;
        logic [19:0] q;
        logic [31:0] qm;
        logic [19:0] rem;
        p   = 52'(x) * 52'(recip);
        q   = p[51:32];
        qm  = 32'(q) * 32'(m);
        rem = x - qm[19:0];
        if (rem >= 20'(m)) begin
            rem = rem - 20'(m);
        end
        return rem;
    endfunction

    // x mod 5^8 for x below 2^40, same scheme.
    function automatic logic [18:0] mod_big(input logic [39:0] x);
        logic [61:0] p;
        logic [21:0] q;
        logic [39:0] qm;
        logic [39:0] rem;
        p   = 62'(x) * 62'(RCP_5_8);
        q   = p[61:40];
        qm  = 40'(q) * M5_8;
        rem = x - qm;
        if (rem >= M5_8) begin
            rem = rem - M5_8;
        end
        return rem[18:0];
    endfunction

    // Bit r is set when r is a sum of two fourth powers mod m. Evaluated
    // at elaboration only.
    function automatic logic [840:0] sum_ok_table(input int m);
        int sq [841];
        int qlist [841];
        int n;
        int s;
        int a;
        int b;
        logic [840:0] isq;
        logic [840:0] res;
        isq   = '0;
        res   = '0;
        n     = 0;
        sq[0] = 0;
        for (a = 1; a < m; a++) begin
            s = sq[a-1] + 2 * a - 1;
            while (s >= m) begin
                s = s - m;
            end
            sq[a] = s;
        end
        for (a = 0; a < m; a++) begin
            if (!isq[sq[sq[a]]]) begin
                isq[sq[sq[a]]] = 1'b1;
                qlist[n] = sq[sq[a]];
                n++;
            end
        end
        for (a = 0; a < n; a++) begin
            for (b = 0; b < n; b++) begin
                s = qlist[a] + qlist[b];
                if (s >= m) begin
                    s = s - m;
                end
                res[s] = 1'b1;
            end
        end
        return res;
    endfunction

    localparam logic [840:0] SUM_OK [NMOD] = '{
        sum_ok_table(625), sum_ok_table(256), sum_ok_table(729), sum_ok_table(343),
        sum_ok_table(121), sum_ok_table(169), sum_ok_table(841)
    };

endpackage

@@ sv/qdsf_front.sv @@
module qdsf_front #(
    parameter int MAX_D = qdsf_pkg::MAX_D_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  qdsf_pkg::t_req_item   i_in_data,
    output logic                  o_in_stall,
    input  logic [15:0]           i_limit,
    input  logic                  i_busy,
    input  logic                  i_full,
    output logic                  o_push,
    output qdsf_pkg::t_work       o_work
);
    import qdsf_pkg::*;

    localparam logic [IDX_W-1:0] DEPTH = IDX_W'(2 * MAX_D + 1);
    localparam logic [D_W-1:0]   MAXV  = D_W'(MAX_D);

    logic        r_valid;
    t_work       r_work;
    t_work       n_work;
    logic        accept;
    logic [D_W-1:0] lim;

    assign o_in_stall = i_busy || (r_valid && i_full);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_full;
    assign o_work     = r_work;
    assign lim        = (i_limit > MAXV) ? MAXV : i_limit;

    always_comb begin
        n_work          = '0;
        n_work.is_test  = i_in_data.req_type;
        n_work.wr_en    = !i_in_data.req_type && (i_in_data.flag_index < DEPTH);
        n_work.wr_idx   = i_in_data.flag_index;
        n_work.wr_val   = i_in_data.flag_value;
        n_work.larger   = i_in_data.larger;
        n_work.smaller  = i_in_data.smaller;
        n_work.range_ok = (i_in_data.smaller != '0) && (i_in_data.smaller < i_in_data.larger)
                          && (i_in_data.larger <= lim);
        n_work.addr_lo  = IDX_W'(i_in_data.larger) - IDX_W'(i_in_data.smaller);
        n_work.addr_hi  = IDX_W'(i_in_data.larger) + IDX_W'(i_in_data.smaller);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work <= n_work;
        end
    end

endmodule

@@ sv/qdsf_queue.sv @@
module qdsf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  qdsf_pkg::t_work  i_work,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output qdsf_pkg::t_work  o_work
);
    import qdsf_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_work          r_mem [QDEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [PW:0]    r_count;

    assign o_full  = (r_count == (PW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_work;
        end
    end

endmodule

@@ sv/qdsf_back.sv @@
module qdsf_back #(
    parameter int MAX_D = qdsf_pkg::MAX_D_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  qdsf_pkg::t_work    i_q_work,
    output logic               o_pop,
    output logic               o_busy,
    output logic               o_out_valid,
    output qdsf_pkg::t_result  o_out_data,
    input  logic               i_out_stall
);
    import qdsf_pkg::*;

    localparam int DEPTH = 2 * MAX_D + 1;
    localparam int AW    = $clog2(DEPTH);

    typedef struct packed {
        logic is_test;
        logic f_range;
        logic f_dres;
        logic f_mod9;
        logic f_c8;
        logic f_4096;
        logic f_bitmap;
    } t_flags;

    logic            en;
    logic            mem [DEPTH];
    logic            r_clearing;
    logic [AW-1:0]   r_clr_addr;

    // stage 1
    logic            r1_valid;
    t_work           r1;
    logic [9:0]      s1_ad [NMOD];
    logic [9:0]      s1_ac [NMOD];
    t_flags          s1_f;
    // stage 2
    logic            r2_valid;
    t_flags          r2_f;
    logic [9:0]      r2_ad [NMOD];
    logic [9:0]      r2_ac [NMOD];
    logic [31:0]     r2_d2;
    logic [31:0]     r2_c2;
    logic            r2_bm_lo;
    logic            r2_bm_hi;
    logic            r2_codd;
    logic [23:0]     s2_w4d;
    logic [23:0]     s2_w4c;
    t_flags          s2_f;
    // stage 3
    logic            r3_valid;
    t_flags          r3_f;
    logic [19:0]     r3_sd [NMOD];
    logic [19:0]     r3_sc [NMOD];
    logic [18:0]     r3_ud;
    logic [18:0]     r3_uc;
    logic [31:0]     r3_d2;
    logic [31:0]     r3_c2;
    // stage 4
    logic            r4_valid;
    t_flags          r4_f;
    logic [9:0]      r4_bd [NMOD];
    logic [9:0]      r4_bc [NMOD];
    logic [37:0]     r4_uud;
    logic [37:0]     r4_uuc;
    logic [63:0]     r4_d4;
    logic [63:0]     r4_c4;
    // stage 5
    logic            r5_valid;
    t_flags          r5_f;
    logic [19:0]     r5_bbd [NMOD];
    logic [19:0]     r5_bbc [NMOD];
    logic [18:0]     r5_vd;
    logic [18:0]     r5_vc;
    logic [63:0]     r5_diff;
    // stage 6
    logic            r6_valid;
    t_flags          r6_f;
    logic [9:0]      r6_ed [NMOD];
    logic [9:0]      r6_ec [NMOD];
    logic            r6_fv5;
    logic [63:0]     r6_diff;
    logic            s6_ftab;
    logic [10:0]     s6_res [NMOD];
    t_reason         s6_rsn;
    // output
    logic            r_out_valid;
    t_result         r_out;

    assign en          = !(r_out_valid && i_out_stall);
    assign o_pop       = en && i_q_valid && !r_clearing;
    assign o_busy      = r_clearing;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Valid bits and clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (en) begin
                r1_valid    <= o_pop;
                r2_valid    <= r1_valid;
                r3_valid    <= r2_valid;
                r4_valid    <= r3_valid;
                r5_valid    <= r4_valid;
                r6_valid    <= r5_valid;
                r_out_valid <= r6_valid && r6_f.is_test;
            end
        end
    end

    // Bitmap: one write port, two registered read ports. Loads write in
    // order with the tests, so a test always sees earlier loads.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= 1'b0;
        end else if (en && r1_valid && r1.wr_en) begin
            mem[r1.wr_idx[AW-1:0]] <= r1.wr_val;
        end
        if (en) begin
            r2_bm_lo <= mem[r1.addr_lo[AW-1:0]];
            r2_bm_hi <= mem[r1.addr_hi[AW-1:0]];
        end
    end

    // Stage 1: reduce d and c by each modulus, simple congruence checks.
    always_comb begin
        for (int k = 0; k < NMOD; k++) begin
            s1_ad[k] = 10'(mod_small(20'(r1.larger), MODS[k], RCPS[k]));
            s1_ac[k] = 10'(mod_small(20'(r1.smaller), MODS[k], RCPS[k]));
        end
        s1_f          = '0;
        s1_f.is_test  = r1.is_test;
        s1_f.f_range  = !r1.range_ok;
        s1_f.f_dres   = (r1.larger[2:0] != 3'd1)
                        || (mod_small(20'(r1.larger), M_5, RCP_5) == '0);
        s1_f.f_mod9   = (mod_small(20'(r1.larger), M_3, RCP_3) == '0)
                        && (mod_small(20'(r1.smaller), M_3, RCP_3) == '0);
        s1_f.f_c8     = !(r1.smaller[2:0] inside {3'd0, 3'd1, 3'd7});
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r1 <= i_q_work;
        end
        if (en) begin
            r2_f    <= s1_f;
            r2_ad   <= s1_ad;
            r2_ac   <= s1_ac;
            r2_d2   <= 32'(r1.larger) * 32'(r1.larger);
            r2_c2   <= 32'(r1.smaller) * 32'(r1.smaller);
            r2_codd <= r1.smaller[0];
        end
    end

    // Stage 2: square the residues, reduce d^2 mod 5^8, mod 4096 check.
    assign s2_w4d = r2_d2[11:0] * r2_d2[11:0];
    assign s2_w4c = r2_c2[11:0] * r2_c2[11:0];

    always_comb begin
        s2_f          = r2_f;
        s2_f.f_4096   = r2_codd && (s2_w4d[11:0] != s2_w4c[11:0]);
        s2_f.f_bitmap = r2_bm_lo || r2_bm_hi;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_f <= s2_f;
            for (int k = 0; k < NMOD; k++) begin
                r3_sd[k] <= 20'(r2_ad[k]) * 20'(r2_ad[k]);
                r3_sc[k] <= 20'(r2_ac[k]) * 20'(r2_ac[k]);
            end
            r3_ud <= mod_big(40'(r2_d2));
            r3_uc <= mod_big(40'(r2_c2));
            r3_d2 <= r2_d2;
            r3_c2 <= r2_c2;
        end
    end

    // Stage 3: reduce squares, square again, full fourth powers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_f <= r3_f;
            for (int k = 0; k < NMOD; k++) begin
                r4_bd[k] <= 10'(mod_small(r3_sd[k], MODS[k], RCPS[k]));
                r4_bc[k] <= 10'(mod_small(r3_sc[k], MODS[k], RCPS[k]));
            end
            r4_uud <= 38'(r3_ud) * 38'(r3_ud);
            r4_uuc <= 38'(r3_uc) * 38'(r3_uc);
            r4_d4  <= 64'(r3_d2) * 64'(r3_d2);
            r4_c4  <= 64'(r3_c2) * 64'(r3_c2);
        end
    end

    // Stage 4: fourth powers of the residues, mod 5^8 fourth powers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_f <= r4_f;
            for (int k = 0; k < NMOD; k++) begin
                r5_bbd[k] <= 20'(r4_bd[k]) * 20'(r4_bd[k]);
                r5_bbc[k] <= 20'(r4_bc[k]) * 20'(r4_bc[k]);
            end
            r5_vd   <= mod_big(40'(r4_uud));
            r5_vc   <= mod_big(40'(r4_uuc));
            r5_diff <= r4_d4 - r4_c4;
        end
    end

    // Stage 5: final residues, 5-adic valuation test.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_f <= r5_f;
            for (int k = 0; k < NMOD; k++) begin
                r6_ed[k] <= 10'(mod_small(r5_bbd[k], MODS[k], RCPS[k]));
                r6_ec[k] <= 10'(mod_small(r5_bbc[k], MODS[k], RCPS[k]));
            end
            r6_fv5  <= (mod_small(20'(r5_vd), M_3125, RCP_3125)
                        == mod_small(20'(r5_vc), M_3125, RCP_3125)) && (r5_vd != r5_vc);
            r6_diff <= r5_diff;
        end
    end

    // Stage 6: table lookups and the first failing check.
    always_comb begin
        s6_ftab = 1'b0;
        for (int k = 0; k < NMOD; k++) begin
            s6_res[k] = 11'(r6_ed[k]) + ((r6_ed[k] < r6_ec[k]) ? 11'(MODS[k]) : 11'd0)
                        - 11'(r6_ec[k]);
            if (k != 0 && !SUM_OK[k][s6_res[k][9:0]]) begin
                s6_ftab = 1'b1;
            end
        end
        if (r6_f.f_range) begin
            s6_rsn = RSN_RANGE;
        end else if (r6_f.f_dres) begin
            s6_rsn = RSN_DRES;
        end else if (r6_ed[0] != r6_ec[0]) begin
            s6_rsn = RSN_MOD625;
        end else if (r6_f.f_mod9) begin
            s6_rsn = RSN_MOD9;
        end else if (r6_f.f_c8) begin
            s6_rsn = RSN_CMOD8;
        end else if (r6_f.f_4096) begin
            s6_rsn = RSN_MOD4096;
        end else if (r6_f.f_bitmap) begin
            s6_rsn = RSN_BITMAP;
        end else if (s6_ftab) begin
            s6_rsn = RSN_TABLES;
        end else if (r6_fv5) begin
            s6_rsn = RSN_V5;
        end else begin
            s6_rsn = RSN_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.accepted      <= (s6_rsn == RSN_OK);
            r_out.difference    <= (s6_rsn == RSN_OK) ? r6_diff : '0;
            r_out.reject_reason <= s6_rsn;
        end
    end

    a_diff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.accepted) |-> (r_out.difference == '0))
        else $error("rejected result carries a nonzero difference");

    a_no_work_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r1_valid && !o_pop))
        else $error("item entered the back end during the clearing sweep");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r6_valid && !r6_f.is_test) |=> !r_out_valid)
        else $error("load item produced a result");

endmodule

@@ sv/quartic_difference_sieve_filter.sv @@
// Quartic difference sieve filter. Load items (req_type 0) write one bit of
// the bad-number bitmap; test items (req_type 1) screen a pair (d, c) and
// each yield one result: an accept flag, d^4 - c^4 when accepted, and the
// first failing check otherwise. Both channels take one transfer per cycle
// in steady state. A test result passes, in order, one front classification
// stage, the four-entry queue, six back stages that walk the residues
// through reduce, square, reduce, square, reduce, and the output register.
// The bitmap memory has one write port and two read ports, which sets one
// item per cycle. After reset the block clears the bitmap, one bit per
// cycle over its 2*MAX_D+1 entries (131071 at the default), and stalls its input
// during that sweep; configuration writes are taken at any time, but should
// only be made while the block is idle.
module quartic_difference_sieve_filter #(
    parameter int MAX_D = qdsf_pkg::MAX_D_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  qdsf_pkg::t_req_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output qdsf_pkg::t_result    o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_data
);
    import qdsf_pkg::*;

    logic [D_W-1:0] r_max_d_limit;
    logic           busy;
    logic           full;
    logic           push;
    t_work          push_work;
    logic           q_valid;
    t_work          q_work;
    logic           pop;

    // The limit register accepts a transfer every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_d_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_d_limit <= i_cfg_data;
        end
    end

    // Front: accepts transfers, clamps the limit, checks range and forms
    // the bitmap addresses d-c and d+c.
    qdsf_front #(.MAX_D(MAX_D)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_limit    (r_max_d_limit),
        .i_busy     (busy),
        .i_full     (full),
        .o_push     (push),
        .o_work     (push_work)
    );

    // Queue decouples the front from stalls at the output.
    qdsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    // Back: bitmap memory, residue pipeline and result register.
    qdsf_back #(.MAX_D(MAX_D)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_work    (q_work),
        .o_pop       (pop),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import qdsf_pkg::*;

    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAP_DEPTH     = 2 * MAX_D_DEFAULT + 1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_req_item   i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_result     o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    quartic_difference_sieve_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow state of the block: the bitmap, the limit and the constant
    // sum-of-two-quartics tables for the six moduli.
    bit           shadow_map [MAP_DEPTH];
    logic [15:0]  shadow_limit;
    int           table_mod [6] = '{256, 729, 343, 121, 169, 841};
    logic [840:0] quartic_sum_ok [6];

    t_req_item    pending_items [$];
    t_result      expected_results [$];

    int  cycle_count;
    int  fail_count;
    int  in_count;
    bit  in_taken;
    int  in_gap;
    int  stall_burst;
    int  hold_left;
    bit  hold_done;
    bit  quiet;

    always #4 i_clk = ~i_clk;

    function automatic longint unsigned pow4_mod(longint unsigned x, longint unsigned m);
        longint unsigned r;
        r = x % m;
        r = r * r % m;
        return r * r % m;
    endfunction

    // Appends an item to the stimulus queue.
    function automatic void add_pending(t_req_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // Appends a prediction to the result queue.
    function automatic void add_expected(t_result res);
        expected_results.insert(expected_results.size(), res);
    endfunction

    // Walks the checks in order and returns the first that fails, or an
    // acceptance carrying d^4 - c^4.
    function automatic t_result screen_pair(logic [15:0] d, logic [15:0] c);
        t_result         res;
        longint unsigned dd;
        longint unsigned cc;
        longint unsigned diff;
        longint unsigned r;
        int              k;
        int              lim;
        dd  = d;
        cc  = c;
        lim = (shadow_limit > MAX_D_DEFAULT) ? MAX_D_DEFAULT : shadow_limit;
        res.accepted      = 1'b0;
        res.difference    = '0;
        res.reject_reason = RSN_OK;
        if (c == 0 || c >= d || d > lim) begin
            res.reject_reason = RSN_RANGE;
        end else if (d % 8 != 1 || d % 5 == 0) begin
            res.reject_reason = RSN_DRES;
        end else if (pow4_mod(dd, 625) != pow4_mod(cc, 625)) begin
            res.reject_reason = RSN_MOD625;
        end else if (d % 3 == 0 && c % 3 == 0) begin
            res.reject_reason = RSN_MOD9;
        end else if (c % 8 != 0 && c % 8 != 1 && c % 8 != 7) begin
            res.reject_reason = RSN_CMOD8;
        end else if (c[0] && pow4_mod(dd, 4096) != pow4_mod(cc, 4096)) begin
            res.reject_reason = RSN_MOD4096;
        end else if (shadow_map[int'(d) - int'(c)] || shadow_map[int'(d) + int'(c)]) begin
            res.reject_reason = RSN_BITMAP;
        end else begin
            for (k = 0; k < 6; k++) begin
                r = (pow4_mod(dd, table_mod[k]) + table_mod[k] - pow4_mod(cc, table_mod[k]))
                    % table_mod[k];
                if (res.reject_reason == RSN_OK && !quartic_sum_ok[k][r]) begin
                    res.reject_reason = RSN_TABLES;
                end
            end
            if (res.reject_reason == RSN_OK) begin
                diff = dd * dd * dd * dd - cc * cc * cc * cc;
                if (diff % 3125 == 0 && diff % 390625 != 0) begin
                    res.reject_reason = RSN_V5;
                end else begin
                    res.accepted   = 1'b1;
                    res.difference = diff;
                end
            end
        end
        return res;
    endfunction

    function automatic t_req_item test_item(int d, int c);
        t_req_item it;
        it            = '0;
        it.req_type   = 1'b1;
        it.flag_index = 17'($urandom);
        it.flag_value = 1'($urandom);
        it.larger     = 16'(d);
        it.smaller    = 16'(c);
        return it;
    endfunction

    function automatic t_req_item load_item(int idx, bit val);
        t_req_item it;
        it            = '0;
        it.req_type   = 1'b0;
        it.flag_index = 17'(idx);
        it.flag_value = val;
        it.larger     = 16'($urandom);
        it.smaller    = 16'($urandom);
        return it;
    endfunction

    // A pair that clears the early congruences: d is 1 mod 8 and prime to 5,
    // c is d times a fourth root of unity mod 625 (1, -1, 182, -182), and c
    // is steered to 0, 1 or 7 mod 8 through its multiple of 625.
    function automatic t_req_item candidate_pair(int lim);
        int unit_root [4] = '{1, 624, 182, 443};
        int c_class [3]   = '{0, 1, 7};
        int d;
        int r;
        int k;
        int kmax;
        int c;
        d = (lim >= 1000) ? $urandom_range(700, lim) : $urandom_range(700, 65535);
        d = d - (d % 8) + 1;
        while (d % 5 == 0) begin
            d = d + 8;
        end
        if (d > 65535) begin
            d = d - 80;
        end
        r    = (d * unit_root[$urandom_range(0, 3)]) % 625;
        k    = (c_class[$urandom_range(0, 2)] - r) & 7;
        kmax = (d - 1 - r) / 625;
        if (kmax >= k) begin
            k = k + 8 * $urandom_range(0, (kmax - k) / 8);
        end else begin
            k = 0;
        end
        c = r + 625 * k;
        return test_item(d, c);
    endfunction

    function automatic t_req_item noise_item();
        t_req_item it;
        it = t_req_item'({$urandom, $urandom, $urandom});
        return it;
    endfunction

    task automatic fill_random(int count, int lim);
        t_req_item it;
        int        sel;
        repeat (count) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                add_pending(candidate_pair(lim));
            end else if (sel < 8) begin
                // Bitmap writes anywhere in the index range 0 to 131071, mostly clearing, so that
                // many pairs still get past the bitmap check.
                it = load_item($urandom_range(0, 131071), ($urandom_range(0, 3) == 0));
                add_pending(it);
            end else begin
                add_pending(noise_item());
            end
        end
    endtask

    task automatic write_limit(logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        shadow_limit = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Waits for every queued item to go in and every result to come out,
    // then lets trailing load items drain through the pipeline.
    task automatic drain();
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Input side: every accepted transfer updates the shadow state in
    // acceptance order, and test items queue one expected result.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            in_taken = 1'b1;
            in_count++;
            if (i_in_data.req_type) begin
                add_expected(screen_pair(i_in_data.larger, i_in_data.smaller));
            end else if (i_in_data.flag_index < MAP_DEPTH) begin
                shadow_map[i_in_data.flag_index] = i_in_data.flag_value;
            end
        end
    end

    // Driver: a new item is presented only once the current one has been
    // transferred, with occasional idle gaps between items.
    always @(negedge i_clk) begin
        if (i_rst_n && (in_taken || !i_in_valid)) begin
            in_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                i_in_data  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(1, 4);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random bursts, plus one long hold-off while the
    // sender keeps pushing so the internal queue fills and backs up.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && in_count >= 120) begin
            hold_done = 1'b1;
            hold_left = 59;
            i_out_stall <= 1'b1;
        end else if (stall_burst > 0) begin
            stall_burst--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_burst = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result checker: each transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.accepted !== want.accepted) begin
                    $display("%0t: accepted expected %0b actual %0b", $time,
                             want.accepted, o_out_data.accepted);
                    fail_count++;
                end
                if (o_out_data.difference !== want.difference) begin
                    $display("%0t: difference expected %0d actual %0d", $time,
                             want.difference, o_out_data.difference);
                    fail_count++;
                end
                if (o_out_data.reject_reason !== want.reject_reason) begin
                    $display("%0t: reject_reason expected %0d actual %0d", $time,
                             want.reject_reason, o_out_data.reject_reason);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        bit [840:0] is_quartic;
        t_req_item  pair;
        int         k;
        int         a;
        int         b;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        cycle_count = 0;
        fail_count  = 0;
        in_count    = 0;
        in_taken    = 1'b0;
        in_gap      = 0;
        stall_burst = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        quiet       = 1'b0;
        shadow_limit = LIMIT_RESET;

        // Residues that are a sum of two fourth powers, per modulus.
        for (k = 0; k < 6; k++) begin
            is_quartic        = '0;
            quartic_sum_ok[k] = '0;
            for (a = 0; a < table_mod[k]; a++) begin
                is_quartic[pow4_mod(a, table_mod[k])] = 1'b1;
            end
            for (a = 0; a < table_mod[k]; a++) begin
                for (b = 0; b < table_mod[k]; b++) begin
                    if (is_quartic[a] && is_quartic[b]) begin
                        quartic_sum_ok[k][(a + b) % table_mod[k]] = 1'b1;
                    end
                end
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the full limit: bitmap edges, the ignored index
        // past the end, range corners, pairs failing the mod 625 check, and a pair
        // knocked out by its own difference in the bitmap.
        write_limit(16'hFFFF);
        add_pending(load_item(0, 1'b1));
        add_pending(load_item(MAP_DEPTH - 1, 1'b1));
        add_pending(load_item(131071, 1'b1));
        add_pending(test_item(0, 0));
        add_pending(test_item(65535, 65535));
        add_pending(test_item(65535, 0));
        add_pending(test_item(17, 33));
        add_pending(test_item(65529, 1));
        add_pending(test_item(41, 3));
        add_pending(test_item(17, 1));
        add_pending(test_item(65521, 65520));
        pair = candidate_pair(65535);
        add_pending(load_item(pair.larger - pair.smaller, 1'b1));
        add_pending(pair);
        add_pending(load_item(pair.larger - pair.smaller, 1'b0));
        add_pending(pair);
        add_pending(load_item(0, 1'b0));
        add_pending(load_item(MAP_DEPTH - 1, 1'b0));
        fill_random(300, 65535);
        drain();

        // Limit zero and one reject every test on range.
        write_limit(16'd0);
        fill_random(30, 65535);
        drain();
        write_limit(16'd1);
        fill_random(20, 65535);
        drain();

        write_limit(16'd40000);
        fill_random(250, 40000);
        drain();

        // Last stretch runs with no idling on either side.
        write_limit(16'hFFFF);
        quiet = 1'b1;
        fill_random(250, 65535);
        drain();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ quartic_difference_sieve_filter.f @@
sv/qdsf_pkg.sv
sv/qdsf_front.sv
sv/qdsf_queue.sv
sv/qdsf_back.sv
sv/quartic_difference_sieve_filter.sv
tb/testbench.sv
